// ===== rtl/core/spq_pkg.sv =====
// Shared types and constants for the sorted priority queue.
package spq_pkg;

  localparam int unsigned CAPACITY = 8;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned ECNT_W   = 4;

  localparam logic signed [DATA_W-1:0] HEAD_EMPTY = '1;

  typedef enum logic [0:0] {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // What every cell sees for the word in flight.
  typedef struct packed {
    logic                     push;
    logic                     pop;
    logic signed [DATA_W-1:0] value;
  } op_t;

  // Cell contents as seen by its neighbors; keep means the entry stays put on a push.
  typedef struct packed {
    logic                     valid;
    logic signed [DATA_W-1:0] value;
    logic                     keep;
  } cell_t;

endpackage

// ===== rtl/core/sorted_priority_queue_unit.sv =====
// A word accepted at one edge shows its result at the output from the next cycle on.
// Throughput: one push or pop per cycle while in_stall_o is low; every cell compares and shifts in the same cycle.
// The single output register frees at the edge it is taken, so a stalled result holds input.
// Reset empties the queue at once (cell valid bits and count clear); entries need no clearing.
// No clearing pass: the queue accepts words as soon as reset is released.
module sorted_priority_queue_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               command_i,
  input  logic signed [spq_pkg::DATA_W-1:0]  value_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [1:0]                         status_o,
  output logic signed [spq_pkg::DATA_W-1:0]  head_value_o,
  output logic                               is_empty_o,
  output logic                               is_full_o,
  output logic [spq_pkg::ECNT_W-1:0]         entry_count_o
);

  localparam int unsigned CAP = spq_pkg::CAPACITY;

  spq_pkg::cell_t cur [CAP];
  spq_pkg::cell_t nxt [CAP];
  spq_pkg::op_t   op;
  spq_pkg::cell_t left_edge, right_edge;

  logic                       in_acc, is_push, full, empty;
  logic [spq_pkg::CNT_W-1:0]  count_q, count_d;
  logic                       out_valid_q;
  spq_pkg::status_e           status_q, status_d;
  logic signed [spq_pkg::DATA_W-1:0] head_q;
  logic                       empty_q, full_q;
  logic [spq_pkg::ECNT_W-1:0] ecnt_q;
  logic [CAP-1:0]             valid_vec;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign is_push    = (spq_pkg::cmd_e'(command_i) == spq_pkg::CMD_PUSH);
  assign full       = cur[CAP-1].valid;
  assign empty      = !cur[0].valid;

  assign op.push  = in_acc && is_push && !full;
  assign op.pop   = in_acc && !is_push && !empty;
  assign op.value = value_i;

  // chain ends: a kept virtual entry before the head, nothing after the tail
  assign left_edge  = '{valid: 1'b1, value: '0, keep: 1'b1};
  assign right_edge = '{valid: 1'b0, value: '0, keep: 1'b0};

  for (genvar i = 0; i < CAP; i++) begin : g_cell
    spq_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .op_i    (op),
      .left_i  ((i == 0) ? left_edge : cur[(i == 0) ? 0 : i-1]),
      .right_i ((i == CAP-1) ? right_edge : cur[(i == CAP-1) ? i : i+1]),
      .cell_o  (cur[i]),
      .nxt_o   (nxt[i])
    );
    assign valid_vec[i] = cur[i].valid;
  end

  always_comb begin
    count_d  = count_q;
    status_d = spq_pkg::ST_DONE;
    if (op.push) begin
      count_d = count_q + spq_pkg::CNT_W'(1);
    end else if (op.pop) begin
      count_d = count_q - spq_pkg::CNT_W'(1);
    end
    if (is_push && full) begin
      status_d = spq_pkg::ST_FULL;
    end else if (!is_push && empty) begin
      status_d = spq_pkg::ST_EMPTY;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        count_q <= count_d;
      end
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      status_q <= status_d;
      head_q   <= nxt[0].valid ? nxt[0].value : spq_pkg::HEAD_EMPTY;
      empty_q  <= !nxt[0].valid;
      full_q   <= nxt[CAP-1].valid;
      ecnt_q   <= spq_pkg::ECNT_W'(count_d);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign head_value_o  = head_q;
  assign is_empty_o    = empty_q;
  assign is_full_o     = full_q;
  assign entry_count_o = ecnt_q;

  // occupied cells always form a prefix of the chain
  a_valid_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_vec & (valid_vec + CAP'(1))) == '0)
    else $error("occupied cells not contiguous from head");

  a_count_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_vec) == int'(count_q))
    else $error("entry count disagrees with cell valid bits");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op.push |=> count_q == $past(count_q) + spq_pkg::CNT_W'(1))
    else $error("accepted push did not add an entry");

  a_refused_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == spq_pkg::ST_FULL) |-> is_full_o)
    else $error("push refused while not full");

  a_refused_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == spq_pkg::ST_EMPTY) |-> is_empty_o)
    else $error("pop refused while not empty");

endmodule

// ===== rtl/core/spq_cell.sv =====
// One slot of the sorted chain: holds an entry, shifts right on push, left on pop.
module spq_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  spq_pkg::op_t     op_i,
  input  spq_pkg::cell_t   left_i,
  input  spq_pkg::cell_t   right_i,
  output spq_pkg::cell_t   cell_o,
  output spq_pkg::cell_t   nxt_o
);

  logic                             valid_q, valid_d;
  logic signed [spq_pkg::DATA_W-1:0] value_q, value_d;
  logic                             keep;

  assign keep = valid_q && (value_q <= op_i.value);

  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    if (op_i.push && !keep) begin
      if (left_i.valid && !left_i.keep) begin
        // left neighbor moves over to make room
        valid_d = 1'b1;
        value_d = left_i.value;
      end else if (left_i.valid) begin
        // insertion point
        valid_d = 1'b1;
        value_d = op_i.value;
      end
    end else if (op_i.pop) begin
      valid_d = right_i.valid;
      value_d = right_i.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign cell_o = '{valid: valid_q, value: value_q, keep: keep};
  assign nxt_o  = '{valid: valid_d, value: value_d, keep: 1'b0};

endmodule
